// ===== hdl/gsmg_pkg.sv =====
// gsmg_pkg: shared types and constants for the grid strip mesh generator.
// No dependencies; used by the divider and the top level.
`default_nettype none

package gsmg_pkg;

	// Result budget caps the effective grid at 30 quads per side.
	localparam int BUDGET_QUADS = 30;

	// Divider geometry: dividends up to 30 * 65536 need 21 bits.
	localparam int DIVIDEND_W = 21;
	localparam int DIVISOR_W  = 5;
	localparam int QUOT_W     = 17;

	// Register map, decoded on paddr[2].
	localparam logic REG_SIDE  = 1'b0;
	localparam logic REG_QUADS = 1'b1;

	// Command codes.
	localparam logic CMD_VERTEX = 1'b0;
	localparam logic CMD_INDEX  = 1'b1;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [QUOT_W-1:0]    quot;
		logic [DIVISOR_W-1:0] rem;
	} div_rsp_t;

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_DIV_SIDE = 8'b0000_0010,
		ST_DIV_TEX  = 8'b0000_0100,
		ST_DIV_PY   = 8'b0000_1000,
		ST_DIV_TV   = 8'b0001_0000,
		ST_EMIT_VTX = 8'b0010_0000,
		ST_EMIT_IDX = 8'b0100_0000,
		ST_EMIT_BAD = 8'b1000_0000
	} state_t;

	typedef enum logic [3:0] {
		PH_LEAD  = 4'b0001,
		PH_HI    = 4'b0010,
		PH_LO    = 4'b0100,
		PH_TRAIL = 4'b1000
	} phase_t;

endpackage

`default_nettype wire

// ===== hdl/gsmg_cmd_if.sv =====
// gsmg_cmd_if: request channel (command, row) with valid/ready.
// Depends on nothing.
`default_nettype none

interface gsmg_cmd_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [4:0] row;

	modport source (output valid, command, row, input ready);
	modport sink   (input valid, command, row, output ready);
endinterface

`default_nettype wire

// ===== hdl/gsmg_res_if.sv =====
// gsmg_res_if: result channel (vertex or strip index) with valid/ready.
// Depends on nothing.
`default_nettype none

interface gsmg_res_if;
	logic        valid;
	logic        ready;
	logic        is_index;
	logic [9:0]  vertex_index;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic [16:0] tex_u;
	logic [16:0] tex_v;
	logic        bad_row;
	logic        last;

	modport source (output valid, is_index, vertex_index, pos_x, pos_y, tex_u, tex_v,
		bad_row, last, input ready);
	modport sink   (input valid, is_index, vertex_index, pos_x, pos_y, tex_u, tex_v,
		bad_row, last, output ready);
endinterface

`default_nettype wire

// ===== hdl/grid_strip_mesh_generator_top.sv =====
// grid_strip_mesh_generator_top: row-at-a-time tessellator for an N x N quad plane.
// Depends on gsmg_pkg, gsmg_cmd_if, gsmg_res_if and gsmg_div.
//
// Usage
//  - req channel: one beat per row request (command, row). Accepted when valid and
//    ready are high at a rising edge; ready is high only while the sequencer is idle.
//  - res channel: one beat per vertex or strip index; last marks a request's final beat.
//    A vertex row gives N+1 beats, a strip row up to 2N+4, an out-of-range row one beat
//    with bad_row set.
//  - APB port: side length at 0x0, quad count at 0x4; write only while idle.
// Timing
//  - A vertex row first runs four divisions (side/N, 65536/N, y*side/N, y*65536/N)
//    through the one shared restoring divider, one after another; then one vertex per
//    cycle while the output register is free, stepped by quotient/remainder accumulation.
//  - A strip row or a bad row needs no division: the emit state loads the first beat
//    once the output register is free, then one beat per cycle while it stays free.
//  - The next request is taken as soon as the final beat is in the output register.
// Reset clears the sequencer, the output valid and the registers (side 1.0, N = 1).
// Backpressure: when res.ready is low the output register holds and the sequencer waits.
`default_nettype none

module grid_strip_mesh_generator_top #(
	parameter int MAX_QUADS = 31
) (
	input  wire         clk,
	input  wire         arst_n,
	// APB configuration
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// streams
	gsmg_cmd_if.sink    req,
	gsmg_res_if.source  res
);

	localparam int N_CAP = (MAX_QUADS < gsmg_pkg::BUDGET_QUADS) ?
		MAX_QUADS : gsmg_pkg::BUDGET_QUADS;

	// ---------------------------------------------------------------- registers
	logic [15:0] side_q;
	logic [4:0]  quads_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q  <= 16'd256;
			quads_q <= 5'd1;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == gsmg_pkg::REG_QUADS)
				quads_q <= pwdata[4:0];
			else
				side_q <= pwdata[15:0];
		end
	end

	always_comb begin
		if (paddr[2] == gsmg_pkg::REG_QUADS)
			prdata = {27'd0, quads_q};
		else
			prdata = {16'd0, side_q};
	end

	// Effective N: zero treated as one, capped by MAX_QUADS and the result budget.
	logic [4:0] n_eff;
	logic [5:0] w_eff;
	logic [10:0] base_full;

	always_comb begin
		priority if (quads_q == 5'd0)
			n_eff = 5'd1;
		else if (quads_q > 5'(N_CAP))
			n_eff = 5'(N_CAP);
		else
			n_eff = quads_q;
		w_eff     = {1'b0, n_eff} + 6'd1;
		base_full = req.row * w_eff;
	end

	// ---------------------------------------------------------------- sequencer state
	gsmg_pkg::state_t state_q;
	gsmg_pkg::phase_t ph_q;
	logic        launch_q;
	logic [4:0]  n_q;
	logic [4:0]  row_q;
	logic        cmd_q;
	logic        trail_q;
	logic [4:0]  x_q;

	// per-row division results
	logic [15:0] qs_q;   // side / N
	logic [4:0]  rs_q;
	logic [16:0] qt_q;   // 65536 / N
	logic [4:0]  rt_q;
	logic [15:0] pos_y_q;
	logic [16:0] tex_v_q;

	// stepping accumulators
	logic [15:0] pa_q;   // floor(x*side/N)
	logic [4:0]  pr_q;
	logic [16:0] ta_q;   // floor(x*65536/N)
	logic [4:0]  tr_q;
	logic [9:0]  lo_q;   // y*w + x
	logic [9:0]  hi_q;   // (y+1)*w + x

	// output register
	logic        out_vld_q;
	logic        o_isi_q;
	logic [9:0]  o_vi_q;
	logic [15:0] o_px_q;
	logic [15:0] o_py_q;
	logic [16:0] o_tu_q;
	logic [16:0] o_tv_q;
	logic        o_bad_q;
	logic        o_last_q;

	assign req.ready        = (state_q == gsmg_pkg::ST_IDLE);
	assign res.valid        = out_vld_q;
	assign res.is_index     = o_isi_q;
	assign res.vertex_index = o_vi_q;
	assign res.pos_x        = o_px_q;
	assign res.pos_y        = o_py_q;
	assign res.tex_u        = o_tu_q;
	assign res.tex_v        = o_tv_q;
	assign res.bad_row      = o_bad_q;
	assign res.last         = o_last_q;

	// Output register free this cycle.
	logic adv;
	assign adv = !out_vld_q || res.ready;

	// ---------------------------------------------------------------- shared divider
	gsmg_pkg::div_req_t div_req;
	gsmg_pkg::div_rsp_t div_rsp;
	logic [20:0] y_side;

	assign y_side = row_q * side_q;

	always_comb begin
		div_req.start   = launch_q;
		div_req.divisor = n_q;
		unique case (state_q)
			gsmg_pkg::ST_DIV_SIDE: div_req.dividend = {5'd0, side_q};
			gsmg_pkg::ST_DIV_TEX:  div_req.dividend = 21'h10000;
			gsmg_pkg::ST_DIV_PY:   div_req.dividend = y_side;
			gsmg_pkg::ST_DIV_TV:   div_req.dividend = {row_q, 16'd0};
			default:               div_req.dividend = '0;
		endcase
	end

	gsmg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Q8.8 position: quotient minus half side, saturated at the top.
	function automatic logic [15:0] pos_sat(input logic [15:0] q, input logic [15:0] s);
		logic signed [16:0] d;
		d = signed'({1'b0, q}) - signed'({2'b0, s[15:1]});
		if (d > 17'sd32767)
			return 16'h7fff;
		return d[15:0];
	endfunction

	// ---------------------------------------------------------------- step unit
	// Adds the per-step quotient and remainder, carrying when the remainder wraps.
	logic [5:0]  pr_sum, tr_sum;
	logic        pr_c, tr_c;
	logic [4:0]  pr_nx, tr_nx;
	logic [15:0] pa_nx;
	logic [16:0] ta_nx;

	always_comb begin
		pr_sum = {1'b0, pr_q} + {1'b0, rs_q};
		pr_c   = pr_sum >= {1'b0, n_q};
		pr_nx  = pr_c ? 5'(pr_sum - {1'b0, n_q}) : pr_sum[4:0];
		pa_nx  = pa_q + qs_q + {15'd0, pr_c};
		tr_sum = {1'b0, tr_q} + {1'b0, rt_q};
		tr_c   = tr_sum >= {1'b0, n_q};
		tr_nx  = tr_c ? 5'(tr_sum - {1'b0, n_q}) : tr_sum[4:0];
		ta_nx  = ta_q + qt_q + {16'd0, tr_c};
	end

	logic bad_req;
	assign bad_req = (req.command == gsmg_pkg::CMD_VERTEX) ? (req.row > n_eff)
	                                                       : (req.row >= n_eff);

	// Divider kick: on a good vertex request, then after each of the first three divisions.
	logic launch_nx;
	logic emitting;

	always_comb begin
		unique case (state_q)
			gsmg_pkg::ST_IDLE:
				launch_nx = req.valid && !bad_req && (req.command == gsmg_pkg::CMD_VERTEX);
			gsmg_pkg::ST_DIV_SIDE, gsmg_pkg::ST_DIV_TEX, gsmg_pkg::ST_DIV_PY:
				launch_nx = div_rsp.done;
			default:
				launch_nx = 1'b0;
		endcase
	end

	// A beat is loaded into the output register in any emit state once it is free.
	assign emitting = adv && ((state_q == gsmg_pkg::ST_EMIT_VTX) ||
		(state_q == gsmg_pkg::ST_EMIT_IDX) || (state_q == gsmg_pkg::ST_EMIT_BAD));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			launch_q <= launch_nx;
			if (emitting)
				out_vld_q <= 1'b1;
			else if (res.ready)
				out_vld_q <= 1'b0;
		end
	end

	// ---------------------------------------------------------------- control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gsmg_pkg::ST_IDLE;
			ph_q    <= gsmg_pkg::PH_HI;
		end else begin
			unique case (state_q)
				gsmg_pkg::ST_IDLE: begin
					if (req.valid) begin
						ph_q <= (req.row != 5'd0) ? gsmg_pkg::PH_LEAD : gsmg_pkg::PH_HI;
						if (bad_req)
							state_q <= gsmg_pkg::ST_EMIT_BAD;
						else if (req.command == gsmg_pkg::CMD_INDEX)
							state_q <= gsmg_pkg::ST_EMIT_IDX;
						else
							state_q <= gsmg_pkg::ST_DIV_SIDE;
					end
				end
				gsmg_pkg::ST_DIV_SIDE: begin
					if (div_rsp.done)
						state_q <= gsmg_pkg::ST_DIV_TEX;
				end
				gsmg_pkg::ST_DIV_TEX: begin
					if (div_rsp.done)
						state_q <= gsmg_pkg::ST_DIV_PY;
				end
				gsmg_pkg::ST_DIV_PY: begin
					if (div_rsp.done)
						state_q <= gsmg_pkg::ST_DIV_TV;
				end
				gsmg_pkg::ST_DIV_TV: begin
					if (div_rsp.done)
						state_q <= gsmg_pkg::ST_EMIT_VTX;
				end
				gsmg_pkg::ST_EMIT_VTX: begin
					if (adv && (x_q == n_q))
						state_q <= gsmg_pkg::ST_IDLE;
				end
				gsmg_pkg::ST_EMIT_IDX: begin
					if (adv) begin
						unique case (ph_q)
							gsmg_pkg::PH_LEAD: ph_q <= gsmg_pkg::PH_HI;
							gsmg_pkg::PH_HI:   ph_q <= gsmg_pkg::PH_LO;
							gsmg_pkg::PH_LO: begin
								if (x_q != n_q)
									ph_q <= gsmg_pkg::PH_HI;
								else if (trail_q)
									ph_q <= gsmg_pkg::PH_TRAIL;
								else
									state_q <= gsmg_pkg::ST_IDLE;
							end
							gsmg_pkg::PH_TRAIL: state_q <= gsmg_pkg::ST_IDLE;
							default: ph_q <= gsmg_pkg::PH_HI;
						endcase
					end
				end
				gsmg_pkg::ST_EMIT_BAD: begin
					if (adv)
						state_q <= gsmg_pkg::ST_IDLE;
				end
				default: state_q <= gsmg_pkg::ST_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------- datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			gsmg_pkg::ST_IDLE: begin
				if (req.valid) begin
					n_q     <= n_eff;
					row_q   <= req.row;
					cmd_q   <= req.command;
					trail_q <= ({1'b0, req.row} + 6'd1) < {1'b0, n_eff};
					x_q     <= '0;
					pa_q    <= '0;
					pr_q    <= '0;
					ta_q    <= '0;
					tr_q    <= '0;
					lo_q    <= base_full[9:0];
					hi_q    <= base_full[9:0] + {4'd0, w_eff};
				end
			end
			gsmg_pkg::ST_DIV_SIDE: begin
				if (div_rsp.done) begin
					qs_q <= div_rsp.quot[15:0];
					rs_q <= div_rsp.rem;
				end
			end
			gsmg_pkg::ST_DIV_TEX: begin
				if (div_rsp.done) begin
					qt_q <= div_rsp.quot;
					rt_q <= div_rsp.rem;
				end
			end
			gsmg_pkg::ST_DIV_PY: begin
				if (div_rsp.done)
					pos_y_q <= pos_sat(div_rsp.quot[15:0], side_q);
			end
			gsmg_pkg::ST_DIV_TV: begin
				if (div_rsp.done)
					tex_v_q <= div_rsp.quot;
			end
			gsmg_pkg::ST_EMIT_VTX: begin
				if (adv) begin
					o_isi_q  <= 1'b0;
					o_vi_q   <= lo_q;
					o_px_q   <= pos_sat(pa_q, side_q);
					o_py_q   <= pos_y_q;
					o_tu_q   <= ta_q;
					o_tv_q   <= tex_v_q;
					o_bad_q  <= 1'b0;
					o_last_q <= (x_q == n_q);
					x_q      <= x_q + 5'd1;
					lo_q     <= lo_q + 10'd1;
					pa_q     <= pa_nx;
					pr_q     <= pr_nx;
					ta_q     <= ta_nx;
					tr_q     <= tr_nx;
				end
			end
			gsmg_pkg::ST_EMIT_IDX: begin
				if (adv) begin
					o_isi_q  <= 1'b1;
					o_px_q   <= '0;
					o_py_q   <= '0;
					o_tu_q   <= '0;
					o_tv_q   <= '0;
					o_bad_q  <= 1'b0;
					unique case (ph_q)
						gsmg_pkg::PH_LEAD: begin
							o_vi_q   <= lo_q;
							o_last_q <= 1'b0;
						end
						gsmg_pkg::PH_HI: begin
							o_vi_q   <= hi_q;
							o_last_q <= 1'b0;
						end
						gsmg_pkg::PH_LO: begin
							o_vi_q   <= lo_q;
							o_last_q <= (x_q == n_q) && !trail_q;
							if (x_q != n_q) begin
								x_q  <= x_q + 5'd1;
								lo_q <= lo_q + 10'd1;
								hi_q <= hi_q + 10'd1;
							end
						end
						gsmg_pkg::PH_TRAIL: begin
							o_vi_q   <= hi_q;
							o_last_q <= 1'b1;
						end
						default: begin
							o_vi_q   <= lo_q;
							o_last_q <= 1'b0;
						end
					endcase
				end
			end
			gsmg_pkg::ST_EMIT_BAD: begin
				if (adv) begin
					o_isi_q  <= cmd_q;
					o_vi_q   <= '0;
					o_px_q   <= '0;
					o_py_q   <= '0;
					o_tu_q   <= '0;
					o_tv_q   <= '0;
					o_bad_q  <= 1'b1;
					o_last_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/gsmg_div.sv =====
// gsmg_div: restoring divider, one quotient bit per cycle, 21-bit dividend by 5-bit divisor.
// Depends on gsmg_pkg.
`default_nettype none

module gsmg_div (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire gsmg_pkg::div_req_t req,
	output gsmg_pkg::div_rsp_t      rsp
);

	localparam int CNT_W = $clog2(gsmg_pkg::DIVIDEND_W + 1);

	logic [gsmg_pkg::DIVIDEND_W-1:0] acc_q;
	logic [gsmg_pkg::DIVISOR_W-1:0]  rem_q;
	logic [gsmg_pkg::DIVISOR_W-1:0]  dvs_q;
	logic [CNT_W-1:0]                cnt_q;
	logic                            busy_q;
	logic                            done_q;

	logic [gsmg_pkg::DIVISOR_W:0] trial;
	logic                         fits;

	always_comb begin
		trial = {rem_q, acc_q[gsmg_pkg::DIVIDEND_W-1]};
		fits  = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(gsmg_pkg::DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			acc_q <= {acc_q[gsmg_pkg::DIVIDEND_W-2:0], fits};
			rem_q <= fits ? gsmg_pkg::DIVISOR_W'(trial - {1'b0, dvs_q})
			              : gsmg_pkg::DIVISOR_W'(trial);
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = acc_q[gsmg_pkg::QUOT_W-1:0];
	assign rsp.rem  = rem_q;

endmodule

`default_nettype wire

// ===== bench/tb_grid_strip_mesh_generator_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for grid_strip_mesh_generator_top: table-driven directed rows,
// then random row requests across several grid settings, all checked beat by beat.
// Depends on gsmg_pkg, gsmg_cmd_if, gsmg_res_if and the top level itself.

module tb_grid_strip_mesh_generator_top;

	localparam int MAX_QUADS = 31;

	// Register byte addresses, one 32-bit word per register.
	localparam logic [2:0] ADDR_SIDE  = {gsmg_pkg::REG_SIDE, 2'b00};
	localparam logic [2:0] ADDR_QUADS = {gsmg_pkg::REG_QUADS, 2'b00};

	// One result beat, laid out as on the result channel.
	typedef struct packed {
		logic               is_index;
		logic [9:0]         vertex_index;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [16:0]        tex_u;
		logic [16:0]        tex_v;
		logic               bad_row;
		logic               last;
	} beat_t;

	// Directed row: optional regrid first, then one request. pins > 0 means the
	// expected beats are typed in below instead of coming from the row planner.
	typedef struct packed {
		logic        regrid;
		logic [15:0] side;
		logic [4:0]  quads;
		logic        cmd;
		logic [4:0]  row;
		logic [1:0]  pins;
		beat_t       pin0;
		beat_t       pin1;
	} probe_t;

	localparam beat_t NIL    = '0;
	// After reset: side 1.0, one quad, so row 0 runs from -0.5 to +0.5.
	localparam beat_t RST_V0 = '{1'b0, 10'd0, -16'sd128, -16'sd128, 17'd0, 17'd0,
		1'b0, 1'b0};
	localparam beat_t RST_V1 = '{1'b0, 10'd1, 16'sd128, -16'sd128, 17'd65536, 17'd0,
		1'b0, 1'b1};
	localparam beat_t BAD_V  = '{gsmg_pkg::CMD_VERTEX, 10'd0, 16'sd0, 16'sd0, 17'd0, 17'd0,
		1'b1, 1'b1};
	localparam beat_t BAD_I  = '{gsmg_pkg::CMD_INDEX, 10'd0, 16'sd0, 16'sd0, 17'd0, 17'd0,
		1'b1, 1'b1};

	localparam int PLAN_LEN = 26;
	localparam probe_t PLAN [PLAN_LEN] = '{
		// reset grid: N = 1, side 1.0
		'{1'b0, 16'd0, 5'd0, gsmg_pkg::CMD_VERTEX, 5'd0, 2'd2, RST_V0, RST_V1},
		'{1'b0, 16'd0, 5'd0, gsmg_pkg::CMD_VERTEX, 5'd1, 2'd0, NIL, NIL},
		'{1'b0, 16'd0, 5'd0, gsmg_pkg::CMD_INDEX, 5'd0, 2'd0, NIL, NIL},
		'{1'b0, 16'd0, 5'd0, gsmg_pkg::CMD_VERTEX, 5'd2, 2'd1, BAD_V, NIL},
		'{1'b0, 16'd0, 5'd0, gsmg_pkg::CMD_INDEX, 5'd1, 2'd1, BAD_I, NIL},
		'{1'b0, 16'd0, 5'd0, gsmg_pkg::CMD_VERTEX, 5'd31, 2'd1, BAD_V, NIL},
		'{1'b0, 16'd0, 5'd0, gsmg_pkg::CMD_INDEX, 5'd31, 2'd1, BAD_I, NIL},
		// zero side, zero quads (taken as one)
		'{1'b1, 16'd0, 5'd0, gsmg_pkg::CMD_VERTEX, 5'd0, 2'd0, NIL, NIL},
		'{1'b0, 16'd0, 5'd0, gsmg_pkg::CMD_INDEX, 5'd0, 2'd0, NIL, NIL},
		// widest side, 31 quads clipped to the 30-quad budget; right edge saturates
		'{1'b1, 16'hFFFF, 5'd31, gsmg_pkg::CMD_VERTEX, 5'd30, 2'd0, NIL, NIL},
		'{1'b0, 16'd0, 5'd0, gsmg_pkg::CMD_VERTEX, 5'd0, 2'd0, NIL, NIL},
		'{1'b0, 16'd0, 5'd0, gsmg_pkg::CMD_INDEX, 5'd0, 2'd0, NIL, NIL},
		'{1'b0, 16'd0, 5'd0, gsmg_pkg::CMD_INDEX, 5'd29, 2'd0, NIL, NIL},
		'{1'b0, 16'd0, 5'd0, gsmg_pkg::CMD_INDEX, 5'd15, 2'd0, NIL, NIL},
		'{1'b0, 16'd0, 5'd0, gsmg_pkg::CMD_VERTEX, 5'd31, 2'd1, BAD_V, NIL},
		'{1'b0, 16'd0, 5'd0, gsmg_pkg::CMD_INDEX, 5'd30, 2'd1, BAD_I, NIL},
		'{1'b1, 16'hFFFF, 5'd30, gsmg_pkg::CMD_VERTEX, 5'd15, 2'd0, NIL, NIL},
		// tiny side: positions round down to the floor
		'{1'b1, 16'd1, 5'd2, gsmg_pkg::CMD_VERTEX, 5'd0, 2'd0, NIL, NIL},
		'{1'b0, 16'd0, 5'd0, gsmg_pkg::CMD_VERTEX, 5'd2, 2'd0, NIL, NIL},
		'{1'b0, 16'd0, 5'd0, gsmg_pkg::CMD_INDEX, 5'd0, 2'd0, NIL, NIL},
		'{1'b0, 16'd0, 5'd0, gsmg_pkg::CMD_INDEX, 5'd1, 2'd0, NIL, NIL},
		// odd side above half scale
		'{1'b1, 16'h8001, 5'd7, gsmg_pkg::CMD_VERTEX, 5'd7, 2'd0, NIL, NIL},
		'{1'b0, 16'd0, 5'd0, gsmg_pkg::CMD_INDEX, 5'd3, 2'd0, NIL, NIL},
		// strip rows: first (no lead), middle (both), last (no trail)
		'{1'b1, 16'd256, 5'd3, gsmg_pkg::CMD_INDEX, 5'd0, 2'd0, NIL, NIL},
		'{1'b0, 16'd0, 5'd0, gsmg_pkg::CMD_INDEX, 5'd1, 2'd0, NIL, NIL},
		'{1'b0, 16'd0, 5'd0, gsmg_pkg::CMD_INDEX, 5'd2, 2'd0, NIL, NIL}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	gsmg_cmd_if row_req ();
	gsmg_res_if mesh_out ();

	grid_strip_mesh_generator_top #(
		.MAX_QUADS(MAX_QUADS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.req    (row_req),
		.res    (mesh_out)
	);

	// Shadow of the two grid registers, as the planner sees them.
	logic [15:0] grid_side;
	logic [4:0]  grid_quads;

	beat_t beats_due[$];  // beats still owed by the block, oldest first
	int    faults;
	bit    steady;        // when set, neither side idles

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case the block locks up.
	initial begin
		#20_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic void fault(input string msg);
		faults++;
		if (faults <= 10) begin
			$display("%s", msg);
		end
	endfunction

	// ---------------------------------------------------------------------
	// Row planner
	// ---------------------------------------------------------------------

	// Quads per side actually used: 0 reads as 1, capped by MAX_QUADS and the result budget.
	function automatic int unsigned grid_n();
		int unsigned n;
		n = (grid_quads == 5'd0) ? 1 : grid_quads;
		if (n > MAX_QUADS) n = MAX_QUADS;
		if (n > gsmg_pkg::BUDGET_QUADS) n = gsmg_pkg::BUDGET_QUADS;
		return n;
	endfunction

	// Q8.8 coordinate of grid line c, centred on zero; only the top can overflow.
	function automatic logic signed [15:0] grid_coord(input int unsigned c,
		input int unsigned n);
		int unsigned prod;
		int          d;
		prod = c * grid_side;
		d = int'(prod / n) - int'(grid_side >> 1);
		if (d > 32767) d = 32767;
		return d[15:0];
	endfunction

	// Q1.16 texture coordinate of grid line c, 65536 at the far edge.
	function automatic logic [16:0] grid_uv(input int unsigned c, input int unsigned n);
		int unsigned q;
		q = (c << 16) / n;
		return q[16:0];
	endfunction

	// Append one owed beat at the tail of the queue.
	function automatic void owe_beat(input beat_t b);
		beats_due = {beats_due, b};
	endfunction

	function automatic void owe_index(input int unsigned v, input bit fin);
		beat_t b;
		b = '0;
		b.is_index     = 1'b1;
		b.vertex_index = v[9:0];
		b.last         = fin;
		owe_beat(b);
	endfunction

	// Queue the beats that one accepted request must produce.
	function automatic void tessellate_row(input logic cmd, input int unsigned y);
		int unsigned n;
		int unsigned w;
		int unsigned v;
		beat_t       b;
		bit          trail;
		n = grid_n();
		w = n + 1;
		if ((cmd == gsmg_pkg::CMD_VERTEX && y > n) ||
			(cmd == gsmg_pkg::CMD_INDEX && y >= n)) begin
			b = '0;
			b.is_index = cmd;
			b.bad_row  = 1'b1;
			b.last     = 1'b1;
			owe_beat(b);
			return;
		end
		if (cmd == gsmg_pkg::CMD_VERTEX) begin
			for (int unsigned x = 0; x <= n; x++) begin
				v = y * w + x;
				b = '0;
				b.vertex_index = v[9:0];
				b.pos_x        = grid_coord(x, n);
				b.pos_y        = grid_coord(y, n);
				b.tex_u        = grid_uv(x, n);
				b.tex_v        = grid_uv(y, n);
				b.last         = (x == n);
				owe_beat(b);
			end
		end else begin
			// degenerate lead joins this segment to the previous row's
			trail = (y + 1 < n);
			if (y > 0) owe_index(y * w, 1'b0);
			for (int unsigned x = 0; x <= n; x++) begin
				owe_index((y + 1) * w + x, 1'b0);
				owe_index(y * w + x, (x == n) && !trail);
			end
			if (trail) owe_index((y + 1) * w + n, 1'b1);
		end
	endfunction

	// ---------------------------------------------------------------------
	// Configuration port
	// ---------------------------------------------------------------------

	// Setup then access; a spare cycle after so back-to-back calls never
	// drive psel twice in one step.
	task automatic reg_access(input logic wr, input logic [2:0] addr,
		input logic [31:0] wdata, output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Regrid while idle, read both registers back, then update the shadow.
	task automatic set_grid(input logic [15:0] side, input logic [4:0] quads);
		logic [31:0] rd;
		reg_access(1'b1, ADDR_SIDE, {16'd0, side}, rd);
		reg_access(1'b1, ADDR_QUADS, {27'd0, quads}, rd);
		reg_access(1'b0, ADDR_SIDE, 32'd0, rd);
		if (rd[15:0] !== side) begin
			fault($sformatf("%0t: side register reads %h, wrote %h", $time, rd[15:0], side));
		end
		reg_access(1'b0, ADDR_QUADS, 32'd0, rd);
		if (rd[4:0] !== quads) begin
			fault($sformatf("%0t: quad count register reads %h, wrote %h", $time, rd[4:0],
				quads));
		end
		grid_side  = side;
		grid_quads = quads;
	endtask

	// ---------------------------------------------------------------------
	// Request side
	// ---------------------------------------------------------------------

	// Offer one row request; valid is left high after the beat so a
	// zero-gap follower keeps it up without a glitch.
	task automatic send_row(input logic cmd, input logic [4:0] row, input bit plan);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			row_req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		row_req.valid   <= 1'b1;
		row_req.command <= cmd;
		row_req.row     <= row;
		do @(posedge clk); while (row_req.ready !== 1'b1);
		if (plan) tessellate_row(cmd, row);
	endtask

	// Drop valid and wait for every owed beat; the block is idle once the
	// final beat has gone, a few spare cycles cover the handover.
	task automatic drain();
		row_req.valid <= 1'b0;
		while (beats_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// ---------------------------------------------------------------------
	// Result side: random stalls, every accepted beat checked in order
	// ---------------------------------------------------------------------
	initial begin : result_sink
		int unsigned stall;
		beat_t       got;
		beat_t       want;
		string       diff;
		wait (arst_n === 1'b1);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 9);
			if (stall != 0) begin
				mesh_out.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			mesh_out.ready <= 1'b1;
			do @(posedge clk); while (mesh_out.valid !== 1'b1);
			got = '{mesh_out.is_index, mesh_out.vertex_index, mesh_out.pos_x,
				mesh_out.pos_y, mesh_out.tex_u, mesh_out.tex_v, mesh_out.bad_row,
				mesh_out.last};
			if (beats_due.size() == 0) begin
				fault($sformatf("%0t: stray beat idx=%0d is_index=%b last=%b", $time,
					got.vertex_index, got.is_index, got.last));
			end else begin
				want = beats_due.pop_front();
				diff = "";
				if (got.is_index !== want.is_index) diff = {diff, " is_index"};
				if (got.vertex_index !== want.vertex_index) diff = {diff, " vertex_index"};
				if (got.pos_x !== want.pos_x) diff = {diff, " pos_x"};
				if (got.pos_y !== want.pos_y) diff = {diff, " pos_y"};
				if (got.tex_u !== want.tex_u) diff = {diff, " tex_u"};
				if (got.tex_v !== want.tex_v) diff = {diff, " tex_v"};
				if (got.bad_row !== want.bad_row) diff = {diff, " bad_row"};
				if (got.last !== want.last) diff = {diff, " last"};
				if (diff != "") begin
					fault($sformatf({"%0t: beat mismatch on%s\n",
						"  exp i=%b idx=%0d x=%0d y=%0d u=%0d v=%0d bad=%b last=%b\n",
						"  got i=%b idx=%0d x=%0d y=%0d u=%0d v=%0d bad=%b last=%b"},
						$time, diff,
						want.is_index, want.vertex_index, want.pos_x, want.pos_y,
						want.tex_u, want.tex_v, want.bad_row, want.last,
						got.is_index, got.vertex_index, got.pos_x, got.pos_y,
						got.tex_u, got.tex_v, got.bad_row, got.last));
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------
	initial begin : stimulus
		probe_t      pr;
		int unsigned n;
		logic        cmd;
		logic [4:0]  row;
		logic [15:0] side;
		logic [4:0]  quads;
		faults     = 0;
		steady     = 1'b0;
		grid_side  = 16'd256;
		grid_quads = 5'd1;
		arst_n          <= 1'b0;
		psel            <= 1'b0;
		penable         <= 1'b0;
		pwrite          <= 1'b0;
		paddr           <= '0;
		pwdata          <= '0;
		row_req.valid   <= 1'b0;
		row_req.command <= gsmg_pkg::CMD_VERTEX;
		row_req.row     <= '0;
		mesh_out.ready  <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: reset grid first, regrid only between drained rows.
		for (int i = 0; i < PLAN_LEN; i++) begin
			pr = PLAN[i];
			if (pr.regrid) begin
				drain();
				set_grid(pr.side, pr.quads);
			end
			if (pr.pins != 2'd0) begin
				owe_beat(pr.pin0);
				if (pr.pins > 2'd1) owe_beat(pr.pin1);
			end
			send_row(pr.cmd, pr.row, pr.pins == 2'd0);
		end

		// Random phases: a fresh grid each, extremes first; every third phase
		// runs with no idling on either side.
		for (int p = 0; p < 8; p++) begin
			drain();
			case (p)
				0: begin
					side  = 16'hFFFF;
					quads = 5'd31;
				end
				1: begin
					side  = 16'd0;
					quads = 5'd0;
				end
				2: begin
					side  = 16'd1;
					quads = 5'd1;
				end
				default: begin
					side  = 16'($urandom_range(0, 65535));
					quads = 5'($urandom_range(0, 31));
				end
			endcase
			set_grid(side, quads);
			steady = (p % 3 == 2);
			n = grid_n();
			for (int k = 0; k < 50; k++) begin
				cmd = 1'($urandom_range(0, 1));
				// mostly rows inside the grid, the rest anywhere in the field
				if ($urandom_range(0, 99) < 85) begin
					row = (cmd == gsmg_pkg::CMD_VERTEX) ? 5'($urandom_range(0, n)) :
						5'($urandom_range(0, n - 1));
				end else begin
					row = 5'($urandom_range(0, 31));
				end
				send_row(cmd, row, 1'b1);
			end
		end

		// Everything owed must arrive; then watch a while for strays.
		drain();
		steady = 1'b0;
		repeat (200) @(posedge clk);
		if (faults == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
